// ===== design/hmd_pkg.sv =====
// Shared types and codes for the H-bridge direction controller.
package hmd_pkg;

    localparam int DUTY_W  = 12;
    localparam int SPEED_W = 8;
    localparam int PHASE_W = 16;
    localparam int BRAKE_W = 8;

    // Opcodes carried on the input word's tuser
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_FWD   = 3'd1;
    localparam logic [2:0] OP_BWD   = 3'd2;
    localparam logic [2:0] OP_OSC   = 3'd3;
    localparam logic [2:0] OP_SPEED = 3'd4;
    localparam logic [2:0] OP_STOP  = 3'd5;

    // motor_mode codes as reported in the result word
    localparam logic [1:0] MCODE_STOP  = 2'd0;
    localparam logic [1:0] MCODE_FWD   = 2'd1;
    localparam logic [1:0] MCODE_BWD   = 2'd2;
    localparam logic [1:0] MCODE_BRAKE = 2'd3;

    // Register index (word address bit)
    localparam logic REG_PHASE = 1'b0;
    localparam logic REG_BRAKE = 1'b1;

    localparam logic [PHASE_W-1:0] PHASE_RESET = 16'd1000;
    localparam logic [BRAKE_W-1:0] BRAKE_RESET = 8'd10;

    typedef enum logic [3:0] {
        MODE_STOP  = 4'b0001,
        MODE_FWD   = 4'b0010,
        MODE_BWD   = 4'b0100,
        MODE_BRAKE = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [SPEED_W-1:0] speed_pct;
        logic               driver_ready;
    } item_t;

    typedef struct packed {
        logic              oscillating;
        logic [1:0]        motor_mode;
        logic              accepted;
        logic [DUTY_W-1:0] pwm_duty;
        logic              pin_b;
        logic              pin_a;
    } result_t;

endpackage

// ===== design/hmd_duty.sv =====
// Speed percent to PWM duty conversion through a constant table.
module hmd_duty
    import hmd_pkg::*;
#(
    parameter int MAX_DUTY_VALUE = 4095
)
(
    input  logic [SPEED_W-1:0] pct,
    output logic [DUTY_W-1:0]  duty
);

    localparam int DUTY_FIELD_MAX = (1 << DUTY_W) - 1;
    localparam int FULL_DUTY = (MAX_DUTY_VALUE > DUTY_FIELD_MAX) ? DUTY_FIELD_MAX
                                                                 : MAX_DUTY_VALUE;

    logic [DUTY_W-1:0] duty_lut [100];

    genvar i;
    generate
        for (i = 0; i < 100; i++)
        begin : g_lut
            localparam int RAW = (i * MAX_DUTY_VALUE) / 100;
            localparam int VAL = (RAW > DUTY_FIELD_MAX) ? DUTY_FIELD_MAX : RAW;
            assign duty_lut[i] = DUTY_W'(VAL);
        end
    endgenerate

    // Anything at or above 100 percent saturates
    assign duty = (pct >= SPEED_W'(100)) ? DUTY_W'(FULL_DUTY) : duty_lut[pct[6:0]];

endmodule

// ===== design/hmd_core.sv =====
// Motor mode state, brake and oscillation timers, and per-word result logic.
module hmd_core
    import hmd_pkg::*;
#(
    parameter int MAX_DUTY_VALUE = 4095,
    parameter int DEFAULT_SPEED  = 50
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  item_t              item,
    input  logic [PHASE_W-1:0] phase_ms,
    input  logic [BRAKE_W-1:0] brake_ms,
    output result_t            result
);

    typedef struct packed {
        mode_t              mode;
        logic               pend;
        logic [DUTY_W-1:0]  duty;
        logic [BRAKE_W-1:0] brake_cnt;
    } drv_t;

    mode_t              mode_reg, mode_next;
    logic               pend_reg, pend_next;
    logic [DUTY_W-1:0]  duty_reg, duty_next;
    logic               osc_reg, osc_next;
    logic [SPEED_W-1:0] osc_speed_reg, osc_speed_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [BRAKE_W-1:0] brake_cnt_reg, brake_cnt_next;

    logic [SPEED_W-1:0] osc_req;
    logic [SPEED_W-1:0] pct_a;
    logic [DUTY_W-1:0]  duty_a;
    logic [DUTY_W-1:0]  duty_osc;
    logic               ok;

    // Apply a direction request: brake on reversal when the brake interval is nonzero, retarget while braking
    function automatic drv_t drive(mode_t m, logic pend, logic [BRAKE_W-1:0] bc,
                                   logic dir, logic [DUTY_W-1:0] duty,
                                   logic [BRAKE_W-1:0] brk);
        drv_t r;
        logic opp;
        opp         = dir ? (m == MODE_FWD) : (m == MODE_BWD);
        r.mode      = m;
        r.pend      = pend;
        r.duty      = duty;
        r.brake_cnt = bc;
        priority if (m == MODE_BRAKE)
        begin
            r.pend = dir;
        end
        else if (opp && (brk != '0))
        begin
            r.mode      = MODE_BRAKE;
            r.pend      = dir;
            r.brake_cnt = brk;
        end
        else
        begin
            r.mode = dir ? MODE_BWD : MODE_FWD;
        end
        return r;
    endfunction

    // Oscillation speed request clamped to 1..100
    always_comb
    begin
        priority if (item.speed_pct == '0)
            osc_req = SPEED_W'(1);
        else if (item.speed_pct > SPEED_W'(100))
            osc_req = SPEED_W'(100);
        else
            osc_req = item.speed_pct;
    end

    assign pct_a = (item.opcode == OP_OSC) ? osc_req : item.speed_pct;

    hmd_duty #(.MAX_DUTY_VALUE(MAX_DUTY_VALUE)) u_duty_cmd
    (
        .pct  (pct_a),
        .duty (duty_a)
    );

    hmd_duty #(.MAX_DUTY_VALUE(MAX_DUTY_VALUE)) u_duty_osc
    (
        .pct  (osc_speed_reg),
        .duty (duty_osc)
    );

    always_comb
    begin
        drv_t               d;
        logic [PHASE_W-1:0] pc_inc;
        mode_next      = mode_reg;
        pend_next      = pend_reg;
        duty_next      = duty_reg;
        osc_next       = osc_reg;
        osc_speed_next = osc_speed_reg;
        phase_next     = phase_reg;
        brake_cnt_next = brake_cnt_reg;
        ok             = 1'b1;
        d              = '{mode: mode_reg, pend: pend_reg, duty: duty_reg,
                           brake_cnt: brake_cnt_reg};
        pc_inc         = phase_reg + PHASE_W'(1);

        unique case (item.opcode)
            OP_TICK:
            begin
                priority if (mode_reg == MODE_BRAKE)
                begin
                    if (brake_cnt_reg <= BRAKE_W'(1))
                    begin
                        brake_cnt_next = '0;
                        mode_next      = pend_reg ? MODE_BWD : MODE_FWD;
                    end
                    else
                    begin
                        brake_cnt_next = brake_cnt_reg - BRAKE_W'(1);
                    end
                end
                else if (osc_reg && (mode_reg != MODE_STOP))
                begin
                    phase_next = pc_inc;
                    if (pc_inc >= phase_ms)
                    begin
                        phase_next = '0;
                        if (!item.driver_ready)
                        begin
                            osc_next = 1'b0;
                        end
                        else
                        begin
                            d = drive(mode_reg, pend_reg, brake_cnt_reg,
                                      (mode_reg == MODE_FWD), duty_osc, brake_ms);
                            mode_next      = d.mode;
                            pend_next      = d.pend;
                            duty_next      = d.duty;
                            brake_cnt_next = d.brake_cnt;
                        end
                    end
                end
            end
            OP_FWD, OP_BWD:
            begin
                osc_next = 1'b0;
                if (!item.driver_ready)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    d = drive(mode_reg, pend_reg, brake_cnt_reg,
                              (item.opcode == OP_BWD), duty_a, brake_ms);
                    mode_next      = d.mode;
                    pend_next      = d.pend;
                    duty_next      = d.duty;
                    brake_cnt_next = d.brake_cnt;
                end
            end
            OP_OSC:
            begin
                if (!item.driver_ready)
                begin
                    osc_next = 1'b0;
                    ok       = 1'b0;
                end
                else if (!(osc_reg && (osc_speed_reg == osc_req)))
                begin
                    osc_next       = 1'b1;
                    osc_speed_next = osc_req;
                    phase_next     = '0;
                    d = drive(mode_reg, pend_reg, brake_cnt_reg, 1'b0, duty_a, brake_ms);
                    mode_next      = d.mode;
                    pend_next      = d.pend;
                    duty_next      = d.duty;
                    brake_cnt_next = d.brake_cnt;
                end
            end
            OP_SPEED:
            begin
                if (!item.driver_ready)
                begin
                    osc_next = 1'b0;
                    ok       = 1'b0;
                end
                else if ((mode_reg == MODE_STOP) && !osc_reg)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    duty_next      = duty_a;
                    osc_speed_next = item.speed_pct;
                end
            end
            OP_STOP:
            begin
                osc_next       = 1'b0;
                mode_next      = MODE_STOP;
                duty_next      = '0;
                brake_cnt_next = '0;
                phase_next     = '0;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // Result reflects the state after this word
    always_comb
    begin
        result.pin_a       = (mode_next == MODE_FWD);
        result.pin_b       = (mode_next == MODE_BWD);
        result.pwm_duty    = ((mode_next == MODE_FWD) || (mode_next == MODE_BWD))
                             ? duty_next : '0;
        result.accepted    = ok;
        result.oscillating = osc_next;
        unique case (mode_next)
            MODE_FWD:   result.motor_mode = MCODE_FWD;
            MODE_BWD:   result.motor_mode = MCODE_BWD;
            MODE_BRAKE: result.motor_mode = MCODE_BRAKE;
            default:    result.motor_mode = MCODE_STOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_STOP;
            pend_reg      <= 1'b0;
            duty_reg      <= '0;
            osc_reg       <= 1'b0;
            osc_speed_reg <= SPEED_W'(DEFAULT_SPEED);
            phase_reg     <= '0;
            brake_cnt_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg      <= mode_next;
            pend_reg      <= pend_next;
            duty_reg      <= duty_next;
            osc_reg       <= osc_next;
            osc_speed_reg <= osc_speed_next;
            phase_reg     <= phase_next;
            brake_cnt_reg <= brake_cnt_next;
        end
    end

endmodule

// ===== design/hbridge_motor_direction_controller.sv =====
// Top level of the H-bridge direction controller: stream ports, registers, pipeline.
//
// Input stream s_axis: one word per tick or command. tuser carries the opcode
// (tick, forward, backward, oscillate, set speed, stop); tdata carries the
// speed percent and the driver-ready flag. Output stream m_axis: exactly one
// result word per input word, in order, giving both bridge pins, PWM duty,
// the accepted flag, motor mode and the oscillation flag.
// An APB port holds the oscillation phase length (address 0) and the brake
// interval (address 4); write them only while the stream is idle.
// Each word accepted on s_axis is registered in the input register, evaluated
// against the motor state, and its result is registered in the result register.
// Throughput: one word per cycle while m_axis accepts results; the motor state update
// is a single pass of logic between the input register and the result register.
// When m_axis stalls, the result register holds and one more word may sit in
// the input register; s_axis_tready drops only when both are full.
// Reset clears both stages, stops the motor, ends oscillation and restores
// the register defaults (1000 ms phase, 10 ms brake).
module hbridge_motor_direction_controller
    import hmd_pkg::*;
#(
    parameter int MAX_DUTY_VALUE = 4095,
    parameter int DEFAULT_SPEED  = 50
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] speed_pct, [8] driver_ready
    input  logic [2:0]  s_axis_tuser,   // [2:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [0] pin_a, [1] pin_b, [13:2] pwm_duty,
                                        // [14] accepted, [16:15] motor_mode, [17] oscillating
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic               in_valid_reg;
    item_t              in_item_reg;
    logic               out_valid_reg;
    result_t            out_res_reg;
    result_t            res;
    logic               fire;
    logic [PHASE_W-1:0] phase_ms_reg;
    logic [BRAKE_W-1:0] brake_ms_reg;
    logic               cfg_wr;

    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.opcode       <= s_axis_tuser;
            in_item_reg.speed_pct    <= s_axis_tdata[7:0];
            in_item_reg.driver_ready <= s_axis_tdata[8];
        end
        if (fire)
            out_res_reg <= res;
    end

    hmd_core #(
        .MAX_DUTY_VALUE (MAX_DUTY_VALUE),
        .DEFAULT_SPEED  (DEFAULT_SPEED)
    ) u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .item     (in_item_reg),
        .phase_ms (phase_ms_reg),
        .brake_ms (brake_ms_reg),
        .result   (res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_res_reg};

    // Configuration registers, decoded on the word address bit
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ms_reg <= PHASE_RESET;
            brake_ms_reg <= BRAKE_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_PHASE: phase_ms_reg <= pwdata[PHASE_W-1:0];
                REG_BRAKE: brake_ms_reg <= pwdata[BRAKE_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_PHASE: prdata = {16'b0, phase_ms_reg};
            REG_BRAKE: prdata = {24'b0, brake_ms_reg};
            default:   prdata = '0;
        endcase
    end

endmodule

// ===== design/hmd_checker.sv =====
// Port-level checks for the H-bridge direction controller, bound to the top level.
module hmd_checker
    import hmd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // A stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word dropped or changed under stall");

    // Never drive both bridge legs
    a_no_shoot: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("both bridge pins high");

    // Braking coasts: pins low, duty zero
    a_brake_coast: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[16:15] == MCODE_BRAKE)
            |-> (m_axis_tdata[13:0] == 14'd0))
        else $error("output driven while braking");

    // Pins follow the reported mode
    a_pin_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[16:15] == MCODE_FWD))
                       && (m_axis_tdata[1] == (m_axis_tdata[16:15] == MCODE_BWD)))
        else $error("bridge pins disagree with motor mode");

endmodule

bind hbridge_motor_direction_controller hmd_checker u_hmd_checker (.*);

// ===== tb/tb_hbridge_motor_direction_controller.sv =====
// Self-checking testbench for the H-bridge direction controller: stream stimulus, APB setup.
module tb_hbridge_motor_direction_controller;
    import hmd_pkg::*;

    localparam int PEAK_DUTY      = 4095;
    localparam int START_SPEED    = 50;
    localparam int DUTY_FIELD_MAX = (1 << DUTY_W) - 1;
    localparam int SPEED_CEIL     = 100;
    localparam int SETTLE_CYCLES  = 4;
    localparam int MAX_REPORTS    = 10;

    // Opcodes the block does not define; it must refuse them
    localparam logic [2:0] OP_RSVD_A = 3'd6;
    localparam logic [2:0] OP_RSVD_B = 3'd7;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BURSTY} rx_style_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [7:0] speed_pct, [8] driver_ready
    logic [2:0]  s_axis_tuser;   // [2:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [0] pin_a, [1] pin_b, [13:2] pwm_duty,
                                 // [14] accepted, [16:15] motor_mode, [17] oscillating
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hbridge_motor_direction_controller #(
        .MAX_DUTY_VALUE(PEAK_DUTY),
        .DEFAULT_SPEED (START_SPEED)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Motor state as the block should hold it
    logic [1:0]         m_mode;
    logic               m_pend_bwd;
    logic [DUTY_W-1:0]  m_duty;
    logic               m_osc;
    logic [SPEED_W-1:0] m_osc_speed;
    logic [PHASE_W-1:0] m_phase_cnt;
    logic [BRAKE_W-1:0] m_brake_cnt;
    logic [PHASE_W-1:0] cfg_phase;
    logic [BRAKE_W-1:0] cfg_brake;

    result_t bridge_outputs_q[$];
    int      errors;
    int      burst_left;
    bit      gaps_on;
    int      holdoff_left;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [DUTY_W-1:0] duty_for(input logic [SPEED_W-1:0] pct);
        int d;
        d = (int'(pct) * PEAK_DUTY) / SPEED_CEIL;
        if (d > PEAK_DUTY)
            d = PEAK_DUTY;
        if (d > DUTY_FIELD_MAX)
            d = DUTY_FIELD_MAX;
        return d[DUTY_W-1:0];
    endfunction

    // Apply a direction, braking first when it reverses the current one and the brake interval is nonzero
    function automatic void steer(input logic to_bwd, input logic [DUTY_W-1:0] duty);
        logic [1:0] opposite;
        opposite = to_bwd ? MCODE_FWD : MCODE_BWD;
        if (m_mode == MCODE_BRAKE)
        begin
            m_pend_bwd = to_bwd;
            m_duty     = duty;
        end
        else if (m_mode == opposite && cfg_brake != 0)
        begin
            m_mode      = MCODE_BRAKE;
            m_pend_bwd  = to_bwd;
            m_duty      = duty;
            m_brake_cnt = cfg_brake;
        end
        else
        begin
            m_mode = to_bwd ? MCODE_BWD : MCODE_FWD;
            m_duty = duty;
        end
    endfunction

    function automatic void advance_ms(input logic rdy);
        if (m_mode == MCODE_BRAKE)
        begin
            if (m_brake_cnt <= 1)
            begin
                m_brake_cnt = '0;
                m_mode      = m_pend_bwd ? MCODE_BWD : MCODE_FWD;
            end
            else
                m_brake_cnt = m_brake_cnt - BRAKE_W'(1);
        end
        else if (m_osc && m_mode != MCODE_STOP)
        begin
            m_phase_cnt = m_phase_cnt + PHASE_W'(1);
            if (m_phase_cnt >= cfg_phase)
            begin
                m_phase_cnt = '0;
                if (!rdy)
                    m_osc = 1'b0;
                else
                    steer(m_mode == MCODE_FWD, duty_for(m_osc_speed));
            end
        end
    endfunction

    function automatic result_t motor_response(input logic [2:0] op,
                                               input logic [SPEED_W-1:0] spd,
                                               input logic rdy);
        result_t            r;
        logic               ok;
        logic [SPEED_W-1:0] s;
        ok = 1'b1;
        case (op)
            OP_TICK:
                advance_ms(rdy);
            OP_FWD, OP_BWD:
            begin
                m_osc = 1'b0;
                if (!rdy)
                    ok = 1'b0;
                else
                    steer(op == OP_BWD, duty_for(spd));
            end
            OP_OSC:
            begin
                s = spd;
                if (s < 1)
                    s = SPEED_W'(1);
                if (s > SPEED_CEIL)
                    s = SPEED_W'(SPEED_CEIL);
                if (!rdy)
                begin
                    m_osc = 1'b0;
                    ok    = 1'b0;
                end
                else if (!(m_osc && m_osc_speed == s))
                begin
                    m_osc       = 1'b1;
                    m_osc_speed = s;
                    m_phase_cnt = '0;
                    steer(1'b0, duty_for(s));
                end
            end
            OP_SPEED:
            begin
                if (!rdy)
                begin
                    m_osc = 1'b0;
                    ok    = 1'b0;
                end
                else if (m_mode == MCODE_STOP && !m_osc)
                    ok = 1'b0;
                else
                begin
                    m_duty      = duty_for(spd);
                    m_osc_speed = spd;
                end
            end
            OP_STOP:
            begin
                m_osc       = 1'b0;
                m_mode      = MCODE_STOP;
                m_duty      = '0;
                m_brake_cnt = '0;
                m_phase_cnt = '0;
            end
            default:
                ok = 1'b0;
        endcase
        r.pin_a       = (m_mode == MCODE_FWD);
        r.pin_b       = (m_mode == MCODE_BWD);
        r.pwm_duty    = (m_mode == MCODE_FWD || m_mode == MCODE_BWD) ? m_duty : '0;
        r.accepted    = ok;
        r.motor_mode  = m_mode;
        r.oscillating = m_osc;
        return r;
    endfunction

    // Offer one word; with gaps on, gaps fall between random-length bursts
    task automatic send_word(input logic [2:0] op, input logic [SPEED_W-1:0] spd,
                             input logic rdy);
        int gap;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(0, 4);
                if (gap > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, rdy, spd};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bridge_outputs_q.push_back(motor_response(op, spd, rdy));
    endtask

    // Drop valid and hold until every result is back and the pipe is empty
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (bridge_outputs_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic reg_sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_sel == REG_PHASE)
            cfg_phase = value[PHASE_W-1:0];
        else
            cfg_brake = value[BRAKE_W-1:0];
        @(posedge clk);
    endtask

    task automatic report(input string what, input result_t want, input result_t got);
        errors++;
        if (errors <= MAX_REPORTS)
        begin
            $display("%s: expected a=%0b b=%0b duty=%0d acc=%0b mode=%0d osc=%0b",
                     what, want.pin_a, want.pin_b, want.pwm_duty, want.accepted,
                     want.motor_mode, want.oscillating);
            $display("    got a=%0b b=%0b duty=%0d acc=%0b mode=%0d osc=%0b",
                     got.pin_a, got.pin_b, got.pwm_duty, got.accepted,
                     got.motor_mode, got.oscillating);
        end
    endtask

    // Result checker
    initial
    begin
        result_t got;
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[$bits(result_t)-1:0];
                if (bridge_outputs_q.size() == 0)
                begin
                    want = '0;
                    report("unexpected word", want, got);
                end
                else
                begin
                    want = bridge_outputs_q.pop_front();
                    if (got.pin_a !== want.pin_a || got.pin_b !== want.pin_b ||
                        got.pwm_duty !== want.pwm_duty || got.accepted !== want.accepted ||
                        got.motor_mode !== want.motor_mode ||
                        got.oscillating !== want.oscillating)
                        report("mismatch", want, got);
                end
            end
        end
    end

    // Receiver stall pattern; a requested hold-off overrides it
    initial
    begin
        rx_style_t style;
        int        span;
        style = RX_OPEN;
        span  = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_left > 0)
            begin
                m_axis_tready <= 1'b0;
                holdoff_left--;
            end
            else
            begin
                if (span == 0)
                begin
                    style = rx_style_t'($urandom_range(0, 3));
                    span  = $urandom_range(20, 80);
                end
                span--;
                case (style)
                    RX_OPEN:   m_axis_tready <= 1'b1;
                    RX_LIGHT:  m_axis_tready <= ($urandom_range(0, 3) != 0);
                    RX_HEAVY:  m_axis_tready <= ($urandom_range(0, 9) < 3);
                    default:   m_axis_tready <= ((span % 4) < 2);
                endcase
            end
        end
    end

    function automatic logic [SPEED_W-1:0] pick_speed();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return SPEED_W'(SPEED_CEIL);
            2:       return '1;
            3, 4:    return SPEED_W'($urandom_range(0, 255));
            default: return SPEED_W'($urandom_range(1, SPEED_CEIL));
        endcase
    endfunction

    task automatic test_commands();
        send_word(OP_SPEED, 8'd40, 1'b1);    // refused while stopped
        send_word(OP_FWD, 8'd255, 1'b0);     // driver not ready
        send_word(OP_FWD, 8'd255, 1'b1);     // duty clamps
        send_word(OP_FWD, 8'd0, 1'b1);
        send_word(OP_SPEED, 8'd100, 1'b1);
        send_word(OP_BWD, 8'd1, 1'b1);       // reversal starts braking
        send_word(OP_FWD, 8'd7, 1'b1);       // replace pending direction
        send_word(OP_SPEED, 8'd99, 1'b1);    // target duty only
        send_word(OP_STOP, 8'd0, 1'b0);      // stop ignores driver_ready
        send_word(OP_RSVD_A, 8'd255, 1'b1);
        send_word(OP_RSVD_B, 8'd0, 1'b0);
        send_word(OP_TICK, 8'd0, 1'b0);
    endtask

    task automatic test_oscillation();
        wait_idle();
        cfg_write(REG_PHASE, 32'd2);
        cfg_write(REG_BRAKE, 32'd1);
        send_word(OP_OSC, 8'd0, 1'b1);       // speed clamps to one
        send_word(OP_OSC, 8'd1, 1'b1);       // same speed, no restart
        send_word(OP_TICK, 8'd0, 1'b1);
        send_word(OP_TICK, 8'd0, 1'b1);      // phase ends, brake
        send_word(OP_TICK, 8'd0, 1'b1);
        send_word(OP_TICK, 8'd0, 1'b1);
        send_word(OP_TICK, 8'd0, 1'b0);      // phase ends with driver not ready
        send_word(OP_OSC, 8'd255, 1'b1);
        send_word(OP_SPEED, 8'd200, 1'b1);
        send_word(OP_OSC, 8'd100, 1'b0);
        send_word(OP_SPEED, 8'd20, 1'b0);
        wait_idle();
        cfg_write(REG_BRAKE, 32'd0);
        send_word(OP_FWD, 8'd60, 1'b1);
        send_word(OP_BWD, 8'd60, 1'b1);      // no brake time: reverse at once
    endtask

    task automatic random_traffic(input int count);
        int          i;
        int          r;
        logic [2:0]  op;
        logic        rdy;
        for (i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                op = OP_TICK;
            else if (r < 64)
                op = OP_FWD;
            else if (r < 73)
                op = OP_BWD;
            else if (r < 83)
                op = OP_OSC;
            else if (r < 91)
                op = OP_SPEED;
            else if (r < 96)
                op = OP_STOP;
            else
                op = (r[0]) ? OP_RSVD_A : OP_RSVD_B;
            rdy = ($urandom_range(0, 9) != 0);
            send_word(op, pick_speed(), rdy);
        end
    endtask

    task automatic test_random_settings();
        logic [PHASE_W-1:0] phases[6];
        logic [BRAKE_W-1:0] brakes[6];
        int                 k;
        phases = '{16'd3, 16'd0, 16'd7, 16'd1, 16'd100, 16'hFFFF};
        brakes = '{8'd2, 8'd0, 8'd255, 8'd1, 8'd5, 8'd10};
        for (k = 0; k < 6; k++)
        begin
            wait_idle();
            cfg_write(REG_PHASE, {16'b0, phases[k]});
            cfg_write(REG_BRAKE, {24'b0, brakes[k]});
            gaps_on = (k % 3 != 2);
            random_traffic(280);
        end
    endtask

    // Hold the receiver off while words keep coming, then drain fully
    task automatic test_backpressure();
        int i;
        wait_idle();
        cfg_write(REG_PHASE, 32'd4);
        cfg_write(REG_BRAKE, 32'd3);
        gaps_on = 1'b0;
        holdoff_left = 300;
        send_word(OP_OSC, 8'd70, 1'b1);
        for (i = 0; i < 40; i++)
            send_word((i % 9 == 8) ? OP_SPEED : OP_TICK, pick_speed(), 1'b1);
        wait_idle();
        gaps_on = 1'b1;
    endtask

    initial
    begin
        errors       = 0;
        burst_left   = 0;
        gaps_on      = 1'b1;
        holdoff_left = 0;
        cfg_phase    = PHASE_RESET;
        cfg_brake    = BRAKE_RESET;
        m_mode       = MCODE_STOP;
        m_pend_bwd   = 1'b0;
        m_duty       = '0;
        m_osc        = 1'b0;
        m_osc_speed  = SPEED_W'(START_SPEED);
        m_phase_cnt  = '0;
        m_brake_cnt  = '0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_TICK;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_commands();
        test_oscillation();
        test_backpressure();
        test_random_settings();

        wait_idle();
        repeat (10) @(posedge clk);
        errors += bridge_outputs_q.size();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
